// ----- src/rcda_pkg.sv -----
// Package for the read coverage difference accumulator.
// Holds field widths, register indexes, reset values and the structs
// that pass between the controller, the datapath and the register file.
package rcda_pkg;

   localparam int REGION_DEPTH_DEF = 1024;
   localparam int DEPTH_BITS_DEF   = 24;

   localparam int COORD_W    = 31;
   localparam int LEN_CFG_W  = 11;
   localparam int STRAND_W   = 2;
   localparam int QUAL_W     = 8;
   localparam int OFFSET_W   = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // register indexes, byte address is 4 * index
   localparam logic [REG_IDX_W-1:0] REG_REGION_START  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_REGION_LENGTH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_REGION_STRAND = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIN_QUALITY   = 2'd3;

   localparam logic [COORD_W-1:0]   RST_REGION_START  = '0;
   localparam logic [LEN_CFG_W-1:0] RST_REGION_LENGTH = 11'd1;
   localparam logic [STRAND_W-1:0]  RST_REGION_STRAND = 2'd1;
   localparam logic [QUAL_W-1:0]    RST_MIN_QUALITY   = '0;

   typedef struct packed {
      logic [COORD_W-1:0]   region_start;
      logic [LEN_CFG_W-1:0] region_length;
      logic [STRAND_W-1:0]  region_strand;
      logic [QUAL_W-1:0]    min_quality;
   } cfg_type;

   // controller -> datapath strobes
   typedef struct packed {
      logic ready;       // take an input item
      logic load_pos;    // register the two delta positions of a read
      logic clr_en;      // write zero at the clear counter
      logic rd1;         // read entry at first position
      logic wr1_rd2;     // write first entry, read second
      logic wr2;         // write second entry
      logic drn_rd;      // read entry at drain pointer
      logic drn_commit;  // load result, zero entry, advance pointer
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic req_valid;
      logic req_drain;
      logic add_ok;      // read passes quality and overlap tests
      logic en2;         // registered: end delta lies inside region
      logic clr_done;
      logic out_free;
   } dp_status_type;

endpackage

// ----- src/rcda_ifs.sv -----
// Channel interfaces for the read coverage difference accumulator.
// Depends on rcda_pkg for field widths.
interface rcda_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [rcda_pkg::COORD_W-1:0] read_first;
   logic [rcda_pkg::COORD_W-1:0] read_last;
   logic [rcda_pkg::QUAL_W-1:0]  read_quality;

   modport source (output valid, req_type, read_first, read_last, read_quality,
                   input ready);
   modport sink   (input valid, req_type, read_first, read_last, read_quality,
                   output ready);
endinterface

interface rcda_rsp_if #(
   parameter int DEPTH_BITS = rcda_pkg::DEPTH_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [rcda_pkg::OFFSET_W-1:0] offset;
   logic [DEPTH_BITS-1:0]         depth;
   logic                          last;

   modport source (output valid, offset, depth, last, input ready);
   modport sink   (input valid, offset, depth, last, output ready);
endinterface

// ----- src/rcda_csr.sv -----
// APB-style register file for the region configuration.
// Depends on rcda_pkg for register indexes, widths and reset values.
module rcda_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcda_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcda_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcda_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output rcda_pkg::cfg_type                   cfg
);

   rcda_pkg::cfg_type cfg_ff, cfg_in;
   logic [rcda_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rcda_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rcda_pkg::REG_REGION_START:
               cfg_in.region_start  = csr_pwdata[rcda_pkg::COORD_W-1:0];
            rcda_pkg::REG_REGION_LENGTH:
               cfg_in.region_length = csr_pwdata[rcda_pkg::LEN_CFG_W-1:0];
            rcda_pkg::REG_REGION_STRAND:
               cfg_in.region_strand = csr_pwdata[rcda_pkg::STRAND_W-1:0];
            rcda_pkg::REG_MIN_QUALITY:
               cfg_in.min_quality   = csr_pwdata[rcda_pkg::QUAL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rcda_pkg::REG_REGION_START:
            csr_prdata = rcda_pkg::CSR_DATA_W'(cfg_ff.region_start);
         rcda_pkg::REG_REGION_LENGTH:
            csr_prdata = rcda_pkg::CSR_DATA_W'(cfg_ff.region_length);
         rcda_pkg::REG_REGION_STRAND:
            csr_prdata = rcda_pkg::CSR_DATA_W'(cfg_ff.region_strand);
         rcda_pkg::REG_MIN_QUALITY:
            csr_prdata = rcda_pkg::CSR_DATA_W'(cfg_ff.min_quality);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_start  <= rcda_pkg::RST_REGION_START;
         cfg_ff.region_length <= rcda_pkg::RST_REGION_LENGTH;
         cfg_ff.region_strand <= rcda_pkg::RST_REGION_STRAND;
         cfg_ff.min_quality   <= rcda_pkg::RST_MIN_QUALITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/rcda_ctrl.sv -----
// Sequencer for the accumulator: clearing pass, read-modify-write of the
// two delta entries of a read, and the drain read / commit steps.
// Depends on rcda_pkg for the command and status structs.
module rcda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  rcda_pkg::dp_status_type st,
   output rcda_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_RD1   = 3'd3;
   localparam logic [2:0] ST_WR1   = 3'd4;
   localparam logic [2:0] ST_WR2   = 3'd5;
   localparam logic [2:0] ST_DRD   = 3'd6;
   localparam logic [2:0] ST_DOUT  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (st.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (st.req_valid) state_in = st.req_drain ? ST_DRD : ST_CALC;
         end
         ST_CALC: begin
            cmd.load_pos = 1'b1;
            state_in = st.add_ok ? ST_RD1 : ST_IDLE;
         end
         ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = ST_WR1;
         end
         ST_WR1: begin
            cmd.wr1_rd2 = 1'b1;
            state_in = st.en2 ? ST_WR2 : ST_IDLE;
         end
         ST_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DRD: begin
            cmd.drn_rd = 1'b1;
            state_in   = ST_DOUT;
         end
         ST_DOUT: begin
            // hold here while the previous result is still pending
            if (st.out_free) begin
               cmd.drn_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/rcda_dpath.sv -----
// Datapath: item registers, delta position arithmetic, the delta memory,
// running sum, drain pointer and the result register.
// Depends on rcda_pkg and the channel interfaces in rcda_ifs.sv.
module rcda_dpath #(
   parameter int REGION_DEPTH = rcda_pkg::REGION_DEPTH_DEF,
   parameter int DEPTH_BITS   = rcda_pkg::DEPTH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcda_pkg::cfg_type       cfg,
   input  rcda_pkg::dp_cmd_type    cmd,
   output rcda_pkg::dp_status_type st,
   rcda_req_if.sink                req_bus,
   rcda_rsp_if.source              rsp_bus
);

   localparam int PTR_W   = $clog2(REGION_DEPTH);
   localparam int DLEN_W  = $clog2(REGION_DEPTH + 1);
   localparam int LEN_W   = (DLEN_W > rcda_pkg::LEN_CFG_W) ? DLEN_W : rcda_pkg::LEN_CFG_W;
   localparam int SUM_W   = rcda_pkg::COORD_W + 2;
   localparam int DELTA_W = DEPTH_BITS + 1;
   localparam int ACC_W   = DEPTH_BITS + 2;

   localparam logic signed [DELTA_W-1:0] DELTA_HI = {1'b0, {DEPTH_BITS{1'b1}}};
   localparam logic signed [DELTA_W-1:0] DELTA_LO = {1'b1, {DEPTH_BITS{1'b0}}};

   // captured item
   logic                              drain_item_ff;
   logic [rcda_pkg::COORD_W-1:0]      rd_first_ff;
   logic [rcda_pkg::COORD_W-1:0]      rd_last_ff;
   logic [rcda_pkg::QUAL_W-1:0]       rd_qual_ff;
   logic                              take;

   // effective region length
   logic [LEN_W-1:0] cfg_len, eff_len;

   // position arithmetic
   logic signed [SUM_W-1:0] first_x, last_x, loc, len_x, loc_end;
   logic signed [SUM_W-1:0] a1, b1, a2, b2, d1, d2;
   logic                    minus, add_ok, en2;
   logic [PTR_W-1:0]        pos1_ff, pos2_ff, pos1_in, pos2_in;
   logic                    en2_ff;

   // memory
   logic signed [DELTA_W-1:0] delta_mem [REGION_DEPTH];
   logic signed [DELTA_W-1:0] delta_rd_ff, mem_wdata;
   logic [PTR_W-1:0]          mem_waddr, mem_raddr;
   logic                      mem_we, mem_re;
   logic [PTR_W-1:0]          clr_cnt_ff;

   // drain
   logic [PTR_W-1:0]          ptr_ff;
   logic [DEPTH_BITS-1:0]     run_sum_ff;
   logic [LEN_W-1:0]          ptr_x;
   logic                      ptr_ok, fin;
   logic signed [ACC_W-1:0]   acc_sum;
   logic [DEPTH_BITS-1:0]     sum_sat;

   // result register
   logic                          out_valid_ff;
   logic [rcda_pkg::OFFSET_W-1:0] out_offset_ff;
   logic [DEPTH_BITS-1:0]         out_depth_ff;
   logic                          out_last_ff;

   assign req_bus.ready = cmd.ready;
   assign take          = cmd.ready && req_bus.valid;

   always_ff @(posedge clock) begin
      if (take) begin
         drain_item_ff <= req_bus.req_type;
         rd_first_ff   <= req_bus.read_first;
         rd_last_ff    <= req_bus.read_last;
         rd_qual_ff    <= req_bus.read_quality;
      end
   end

   always_comb begin
      cfg_len = LEN_W'(cfg.region_length);
      if (cfg_len == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg_len > LEN_W'(REGION_DEPTH)) begin
         eff_len = LEN_W'(REGION_DEPTH);
      end else begin
         eff_len = cfg_len;
      end
   end

   // plus strand: +1 at first-loc, -1 at last+1-loc
   // minus strand: +1 at loc+len-1-last, -1 at loc+len-first
   always_comb begin
      first_x = SUM_W'(rd_first_ff);
      last_x  = SUM_W'(rd_last_ff);
      loc     = SUM_W'(cfg.region_start);
      len_x   = SUM_W'(eff_len);
      loc_end = loc + len_x;
      minus   = cfg.region_strand[rcda_pkg::STRAND_W-1];
      if (minus) begin
         a1 = loc_end - SUM_W'(1);
         b1 = last_x;
         a2 = loc_end;
         b2 = first_x;
      end else begin
         a1 = first_x;
         b1 = loc;
         a2 = last_x + SUM_W'(1);
         b2 = loc;
      end
      d1 = a1 - b1;
      d2 = a2 - b2;
      add_ok = (rd_qual_ff >= cfg.min_quality) && (first_x <= last_x)
               && (first_x < loc_end) && (last_x >= loc);
      en2 = d2 < len_x;
      pos1_in = d1[SUM_W-1] ? '0 : d1[PTR_W-1:0];
      pos2_in = d2[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pos) begin
         pos1_ff <= pos1_in;
         pos2_ff <= pos2_in;
         en2_ff  <= en2;
      end
   end

   // drain arithmetic
   always_comb begin
      ptr_x   = LEN_W'(ptr_ff);
      ptr_ok  = ptr_x < eff_len;
      fin     = !ptr_ok || (ptr_x == (eff_len - LEN_W'(1)));
      acc_sum = $signed({2'b00, run_sum_ff})
                + $signed({delta_rd_ff[DELTA_W-1], delta_rd_ff});
      if (!ptr_ok) begin
         sum_sat = run_sum_ff;
      end else if (acc_sum[ACC_W-1]) begin
         sum_sat = '0;
      end else if (acc_sum[DEPTH_BITS]) begin
         sum_sat = '1;
      end else begin
         sum_sat = acc_sum[DEPTH_BITS-1:0];
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = pos1_ff;
      mem_raddr = pos1_ff;
      mem_wdata = '0;
      if (cmd.clr_en) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
      end
      if (cmd.rd1) begin
         mem_re = 1'b1;
      end
      if (cmd.wr1_rd2) begin
         mem_we    = 1'b1;
         mem_wdata = (delta_rd_ff == DELTA_HI) ? DELTA_HI : delta_rd_ff + DELTA_W'(1);
         mem_re    = 1'b1;
         mem_raddr = pos2_ff;
      end
      if (cmd.wr2) begin
         mem_we    = 1'b1;
         mem_waddr = pos2_ff;
         mem_wdata = (delta_rd_ff == DELTA_LO) ? DELTA_LO : delta_rd_ff - DELTA_W'(1);
      end
      if (cmd.drn_rd) begin
         mem_re    = ptr_ok;
         mem_raddr = ptr_ff;
      end
      if (cmd.drn_commit) begin
         mem_we    = ptr_ok;
         mem_waddr = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) delta_mem[mem_waddr] <= mem_wdata;
      if (mem_re) delta_rd_ff <= delta_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_cnt_ff <= clr_cnt_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         run_sum_ff <= '0;
      end else if (cmd.drn_commit) begin
         if (fin) begin
            ptr_ff     <= '0;
            run_sum_ff <= '0;
         end else begin
            ptr_ff     <= ptr_ff + PTR_W'(1);
            run_sum_ff <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.drn_commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.drn_commit) begin
         out_offset_ff <= rcda_pkg::OFFSET_W'(ptr_ff);
         out_depth_ff  <= sum_sat;
         out_last_ff   <= fin;
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.offset = out_offset_ff;
   assign rsp_bus.depth  = out_depth_ff;
   assign rsp_bus.last   = out_last_ff;

   assign st.req_valid = req_bus.valid;
   assign st.req_drain = req_bus.req_type;
   assign st.add_ok    = add_ok && !drain_item_ff;
   assign st.en2       = en2_ff;
   assign st.clr_done  = clr_cnt_ff == PTR_W'(REGION_DEPTH - 1);
   assign st.out_free  = !out_valid_ff || rsp_bus.ready;

endmodule

// ----- src/read_coverage_difference_accumulator_unit.sv -----
// Top level of the read coverage difference accumulator.
// Depends on rcda_pkg, rcda_ifs, rcda_csr, rcda_ctrl and rcda_dpath.
//
//   channel   dir   handshake            payload
//   req_bus   in    valid / ready        req_type, read_first, read_last, read_quality
//   rsp_bus   out   valid / ready        offset, depth, last
//   csr_*     in    psel/penable/pready  paddr, pwdata, prdata
//
// Accept to next accept: a read failing the quality or overlap test passes
// through CALC only, one with one delta in the region through CALC, RD1 and
// WR1, one with both also through WR2 (each delta is a read-modify-write on
// the one memory); a drain passes DRD and DOUT. After reset the memory is
// cleared one entry a cycle, every entry, taking no items. A stalled result
// holds in the output register; a following drain waits for it, an add does not.
module read_coverage_difference_accumulator_unit #(
   parameter int REGION_DEPTH = rcda_pkg::REGION_DEPTH_DEF,
   parameter int DEPTH_BITS   = rcda_pkg::DEPTH_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rcda_req_if.sink                        req_bus,
   rcda_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rcda_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcda_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rcda_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   rcda_pkg::cfg_type       cfg;
   rcda_pkg::dp_cmd_type    cmd;
   rcda_pkg::dp_status_type st;

   rcda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcda_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   rcda_dpath #(
      .REGION_DEPTH (REGION_DEPTH),
      .DEPTH_BITS   (DEPTH_BITS)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .st      (st),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // only one sequencer step at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_pos, cmd.clr_en, cmd.rd1, cmd.wr1_rd2, cmd.wr2,
                cmd.drn_rd, cmd.drn_commit}))
      else $error("more than one datapath step active");

   // a result is never loaded over one still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.drn_commit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result register overwritten");

   // no item is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !req_bus.ready)
      else $error("item accepted while clearing");

   // the first write of a read follows its memory read
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      cmd.wr1_rd2 |-> $past(cmd.rd1))
      else $error("delta write without preceding read");

endmodule

// ----- tb/sv/rcda_coverage_checker.sv -----
`timescale 1ns / 100ps
// Item codes shared by the testbench files, and the coverage checker that
// predicts every drained position and compares it with the result channel.
// Depends on rcda_pkg and the channel interfaces in rcda_ifs.
package rcda_tb_pkg;
   localparam logic ITEM_ADD   = 1'b0;
   localparam logic ITEM_DRAIN = 1'b1;

   localparam logic [1:0] STRAND_NONE  = 2'b00;
   localparam logic [1:0] STRAND_PLUS  = 2'b01;
   localparam logic [1:0] STRAND_ODD   = 2'b10;
   localparam logic [1:0] STRAND_MINUS = 2'b11;
endpackage

module rcda_coverage_checker #(
   parameter int REGION_DEPTH = rcda_pkg::REGION_DEPTH_DEF,
   parameter int DEPTH_BITS   = rcda_pkg::DEPTH_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rcda_req_if                             req_mon,
   rcda_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [rcda_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcda_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              pending_results,
   output int                              fail_count
);
   import rcda_pkg::*;
   import rcda_tb_pkg::*;

   localparam longint DEPTH_MAX = (64'sd1 <<< DEPTH_BITS) - 1;
   localparam longint DELTA_MIN = -(64'sd1 <<< DEPTH_BITS);

   typedef struct packed {
      logic [OFFSET_W-1:0]   offset;
      logic [DEPTH_BITS-1:0] depth;
      logic                  last;
   } cov_point_type;

   logic [COORD_W-1:0]   cfg_start;
   logic [LEN_CFG_W-1:0] cfg_len;
   logic [STRAND_W-1:0]  cfg_strand;
   logic [QUAL_W-1:0]    cfg_min_q;

   longint        delta_mem [REGION_DEPTH];
   longint        cov_sum;
   int            walk_ptr;
   cov_point_type coverage_q [$];

   function automatic void clear_coverage();
      foreach (delta_mem[i]) delta_mem[i] = 0;
      cov_sum    = 0;
      walk_ptr   = 0;
      cfg_start  = RST_REGION_START;
      cfg_len    = RST_REGION_LENGTH;
      cfg_strand = RST_REGION_STRAND;
      cfg_min_q  = RST_MIN_QUALITY;
   endfunction

   function automatic void apply_write(input logic [REG_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_REGION_START:  cfg_start  = data[COORD_W-1:0];
         REG_REGION_LENGTH: cfg_len    = data[LEN_CFG_W-1:0];
         REG_REGION_STRAND: cfg_strand = data[STRAND_W-1:0];
         REG_MIN_QUALITY:   cfg_min_q  = data[QUAL_W-1:0];
         default: ;
      endcase
   endfunction

   // zero reads as one, anything past the store depth as the full depth
   function automatic longint region_span();
      longint l;
      l = {53'd0, cfg_len};
      if (l == 0) l = 1;
      if (l > longint'(REGION_DEPTH)) l = longint'(REGION_DEPTH);
      return l;
   endfunction

   function automatic void bump_delta(input longint pos, input longint by);
      longint v;
      if (pos < 0 || pos >= longint'(REGION_DEPTH)) return;
      v = delta_mem[int'(pos)] + by;
      if (v > DEPTH_MAX) v = DEPTH_MAX;
      if (v < DELTA_MIN) v = DELTA_MIN;
      delta_mem[int'(pos)] = v;
   endfunction

   function automatic void add_read(input logic [COORD_W-1:0] first_b,
                                    input logic [COORD_W-1:0] last_b,
                                    input logic [QUAL_W-1:0] qual);
      longint first, lastb, loc, len, pos;
      first = {33'd0, first_b};
      lastb = {33'd0, last_b};
      loc   = {33'd0, cfg_start};
      len   = region_span();
      if (qual < cfg_min_q) return;
      if (first > lastb) return;
      if (!(first < loc + len && lastb >= loc)) return;
      // negative strand codes mirror offsets from the region end
      if (!cfg_strand[STRAND_W-1]) begin
         pos = first - loc;
         bump_delta(pos > 0 ? pos : 0, 1);
         pos = lastb + 1 - loc;
         if (pos < len) bump_delta(pos, -1);
      end else begin
         pos = loc + len - 1 - lastb;
         bump_delta(pos > 0 ? pos : 0, 1);
         pos = loc + len - first;
         if (pos < len) bump_delta(pos, -1);
      end
   endfunction

   function automatic cov_point_type drain_position();
      longint        len, sum;
      logic          fin;
      cov_point_type pt;
      len = region_span();
      if (longint'(walk_ptr) >= len || walk_ptr >= REGION_DEPTH) begin
         // length lowered under the walk: flag last and restart
         fin = 1'b1;
         sum = cov_sum;
      end else begin
         fin = (longint'(walk_ptr) == len - 1);
         sum = cov_sum + delta_mem[walk_ptr];
         delta_mem[walk_ptr] = 0;
      end
      if (sum > DEPTH_MAX) sum = DEPTH_MAX;
      if (sum < 0) sum = 0;
      pt.offset = walk_ptr[OFFSET_W-1:0];
      pt.depth  = sum[DEPTH_BITS-1:0];
      pt.last   = fin;
      if (fin) begin
         walk_ptr = 0;
         cov_sum  = 0;
      end else begin
         walk_ptr = walk_ptr + 1;
         cov_sum  = sum;
      end
      return pt;
   endfunction

   always @(posedge clock) begin : watch
      cov_point_type want;
      if (reset) begin
         clear_coverage();
         coverage_q.delete();
         fail_count = 0;
         pending_results <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_write(csr_paddr[REG_IDX_W+1:2], csr_pwdata);
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == ITEM_DRAIN)
               coverage_q.insert(coverage_q.size(), drain_position());
            else
               add_read(req_mon.read_first, req_mon.read_last, req_mon.read_quality);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (coverage_q.size() == 0) begin
               $display("%0t unexpected result: offset %0d depth %0d last %0b",
                        $time, rsp_mon.offset, rsp_mon.depth, rsp_mon.last);
               fail_count++;
            end else begin
               want = coverage_q.pop_front();
               if (rsp_mon.offset !== want.offset) begin
                  $display("%0t offset mismatch: expected %0d, got %0d",
                           $time, want.offset, rsp_mon.offset);
                  fail_count++;
               end
               if (rsp_mon.depth !== want.depth) begin
                  $display("%0t depth mismatch at offset %0d: expected %0d, got %0d",
                           $time, want.offset, want.depth, rsp_mon.depth);
                  fail_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $display("%0t last mismatch at offset %0d: expected %0b, got %0b",
                           $time, want.offset, want.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         pending_results <= coverage_q.size();
      end
   end

endmodule

// ----- tb/sv/read_coverage_difference_accumulator_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the read coverage difference accumulator: clock, reset,
// register writes, read and drain items, result back-pressure and verdict.
// Depends on rcda_pkg, rcda_ifs, the block and rcda_coverage_checker.
module read_coverage_difference_accumulator_unit_tb;
   import rcda_pkg::*;
   import rcda_tb_pkg::*;

   localparam int REGION_DEPTH    = REGION_DEPTH_DEF;
   localparam int DEPTH_BITS      = DEPTH_BITS_DEF;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int HOLD_PHASE      = 3;
   localparam longint COORD_MAX   = 64'd2147483647;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
      logic [QUAL_W-1:0]  qual;
   } read_req_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int pending_results;
   int fail_count;
   int cycle_count;
   int rsp_hold_cycles;
   bit calm;

   rcda_req_if req_bus ();
   rcda_rsp_if #(.DEPTH_BITS(DEPTH_BITS)) rsp_bus ();

   read_coverage_difference_accumulator_unit #(
      .REGION_DEPTH(REGION_DEPTH),
      .DEPTH_BITS  (DEPTH_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   rcda_coverage_checker #(
      .REGION_DEPTH(REGION_DEPTH),
      .DEPTH_BITS  (DEPTH_BITS)
   ) i_coverage_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .pending_results(pending_results),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly short idles, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
      longint c;
      c = v;
      if (c < 0) c = 0;
      if (c > COORD_MAX) c = COORD_MAX;
      return c[COORD_W-1:0];
   endfunction

   function automatic read_req_type read_item(input longint first, input longint lastb,
                                              input int qual);
      read_req_type it;
      it.kind  = ITEM_ADD;
      it.first = clamp_coord(first);
      it.last  = clamp_coord(lastb);
      it.qual  = qual[QUAL_W-1:0];
      return it;
   endfunction

   // coordinate fields of a drain item are don't-care, so fill them anyway
   function automatic read_req_type drain_item();
      read_req_type it;
      it.kind  = ITEM_DRAIN;
      it.first = COORD_W'($urandom);
      it.last  = COORD_W'($urandom);
      it.qual  = QUAL_W'($urandom);
      return it;
   endfunction

   function automatic read_req_type noise_item();
      read_req_type it;
      it.kind  = 1'($urandom_range(0, 1));
      it.first = COORD_W'($urandom);
      it.last  = COORD_W'($urandom);
      it.qual  = QUAL_W'($urandom);
      return it;
   endfunction

   // a read landing on or around the region, mostly above the quality gate
   function automatic read_req_type near_read(input longint loc, input longint len,
                                              input int minq);
      longint f, l;
      int     q;
      f = loc + longint'($urandom_range(0, int'(len) + 40)) - 20;
      if ($urandom_range(0, 19) == 0)
         l = f - longint'($urandom_range(1, 5));
      else
         l = f + longint'($urandom_range(0, int'(len) + 8));
      if ($urandom_range(0, 5) == 0)
         q = $urandom_range(0, 255);
      else
         q = $urandom_range(minq, 255);
      return read_item(f, l, q);
   endfunction

   task automatic send_req(input read_req_type it);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= it.kind;
      req_bus.read_first   <= it.first;
      req_bus.read_last    <= it.last;
      req_bus.read_quality <= it.qual;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // unused upper data bits carry junk; the registers keep only their width
   task automatic program_region(input logic [COORD_W-1:0] loc,
                                 input logic [LEN_CFG_W-1:0] len,
                                 input logic [STRAND_W-1:0] strand,
                                 input logic [QUAL_W-1:0] minq);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      write_csr(REG_REGION_START,  {junk[31], loc});
      write_csr(REG_REGION_LENGTH, {junk[31:11], len});
      write_csr(REG_REGION_STRAND, {junk[31:2], strand});
      write_csr(REG_MIN_QUALITY,   {junk[31:8], minq});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // adds give no result, so wait on for SETTLE_CYCLES beyond the last result
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_side
      int n;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      longint loc, len, eff;
      int     minq, r, drain_cut;
      logic [STRAND_W-1:0] strand;

      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= ITEM_ADD;
      req_bus.read_first   <= '0;
      req_bus.read_last    <= '0;
      req_bus.read_quality <= '0;
      calm = 1'b0;
      rsp_hold_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plus strand: gate at threshold, reversed span, clamping, out of region
      program_region(31'd1000, 11'd8, STRAND_PLUS, 8'd10);
      send_req(read_item(1000, 1003, 10));
      send_req(read_item(1000, 1003, 9));
      send_req(read_item(1005, 1002, 200));
      send_req(read_item(0, 1001, 255));
      send_req(read_item(1006, COORD_MAX, 50));
      send_req(read_item(0, 0, 255));
      send_req(read_item(1007, 1007, 10));
      repeat (8) send_req(drain_item());
      settle();

      // zero length acts as one, region at the top of the coordinate range
      program_region(COORD_MAX[COORD_W-1:0], 11'd0, STRAND_MINUS, 8'd0);
      send_req(read_item(COORD_MAX, COORD_MAX, 0));
      repeat (2) send_req(drain_item());
      settle();

      // oversized length and the odd strand code, then length cut mid-walk
      program_region(31'd0, 11'd2047, STRAND_ODD, 8'd255);
      send_req(read_item(0, 5, 255));
      send_req(read_item(3, 9, 254));
      repeat (3) send_req(drain_item());
      settle();
      program_region(31'd0, 11'd2, STRAND_NONE, 8'd255);
      repeat (2) send_req(drain_item());
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0:       loc = 0;
            1:       loc = COORD_MAX - longint'($urandom_range(0, 60));
            2:       loc = longint'($urandom_range(0, 100));
            default: loc = longint'($urandom_range(0, 32'h7fffffff));
         endcase
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = longint'($urandom_range(1000, 2047));
            default: len = longint'($urandom_range(1, 40));
         endcase
         strand = STRAND_W'($urandom_range(0, 3));
         r = $urandom_range(0, 9);
         if (r < 6)       minq = $urandom_range(0, 30);
         else if (r == 6) minq = 255;
         else             minq = $urandom_range(0, 255);
         program_region(loc[COORD_W-1:0], len[LEN_CFG_W-1:0], strand, minq[QUAL_W-1:0]);
         eff = len;
         if (eff == 0) eff = 1;
         if (eff > longint'(REGION_DEPTH)) eff = longint'(REGION_DEPTH);
         calm = (ph % 4 == 1);
         drain_cut = (ph == HOLD_PHASE) ? 80 : 35;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long result stall while drains keep coming: input must back up
            if (ph == HOLD_PHASE && n == 5) rsp_hold_cycles = RSP_HOLD_CYCLES;
            r = $urandom_range(0, 99);
            if (r < drain_cut)
               send_req(drain_item());
            else if (r < 90)
               send_req(near_read(loc, eff, minq));
            else
               send_req(noise_item());
         end
         calm = 1'b0;
         settle();
      end

      settle();
      if (fail_count == 0 && pending_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
